FILE: hw/rtl/clipped_window_median_filter_unit_defines.svh
// Assertion macros shared by the checker files of the median filter unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CLIPPED_WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define CLIPPED_WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define CWMF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define CWMF_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Like CWMF_ASSERT_NEXT, but also checked while reset is applied.
`define CWMF_ASSERT_RST(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

FILE: hw/rtl/cwmf_pkg.sv
// Package of the clipped window median filter: constants, register indexes and types.
// Used by every module of the block; depends on nothing.
package cwmf_pkg;

  localparam int DEF_MAX_COLS    = 1024;
  localparam int DEF_MAX_ROWS    = 4096;
  localparam int DEF_SAMPLE_BITS = 32;

  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 13;
  localparam int COLS_REG_BITS = 11;
  localparam int ROWS_REG_BITS = 13;
  localparam int ROW_OUT_BITS  = 12;
  localparam int COL_OUT_BITS  = 10;

  localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_COLS = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_ROWS = 2'd1;

  localparam int RST_GRID_COLS = 1024;
  localparam int RST_GRID_ROWS = 4096;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_DRAIN  = 1'b1;

  localparam int WIN_N  = 9;
  localparam int SORT_N = 10;

  typedef struct packed {
    logic valid;
    logic drain;
    logic emit_a;
    logic emit_b;
    logic use_older;
    logic a_col0;
    logic b_col1;
    logic cap0;
    logic cap1;
    logic has_l;
    logic has_r;
    logic last;
  } item_ctl_t;

  typedef struct packed {
    logic                    vld;
    logic                    odd;
    logic                    last;
    logic [ROW_OUT_BITS-1:0] row;
    logic [COL_OUT_BITS-1:0] col;
  } lane_meta_t;

endpackage

FILE: hw/rtl/cwmf_lines.sv
// Line stores, forwarding, 3x3 window and drain columns of the median filter.
// Builds the padded sorter lanes for each transfer; uses cwmf_pkg.
module cwmf_lines
  import cwmf_pkg::*;
#(
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  item_ctl_t                             ctl_in,
  input  logic [AW-1:0]                         addr_in,
  input  logic [SAMPLE_BITS-1:0]                samp_in,
  input  logic [ROW_OUT_BITS-1:0]               row_in,
  input  logic [COL_OUT_BITS-1:0]               col_in,
  output logic [SORT_N-1:0][SAMPLE_BITS:0]      lane_a_r,
  output logic [SORT_N-1:0][SAMPLE_BITS:0]      lane_b_r,
  output lane_meta_t                            meta_a_r,
  output lane_meta_t                            meta_b_r
);

  localparam int SB = SAMPLE_BITS;

  logic [SB-1:0] older_mem [MAX_COLS];
  logic [SB-1:0] prev_mem  [MAX_COLS];

  item_ctl_t             ctl_r;
  logic [AW-1:0]         addr_r;
  logic [SB-1:0]         samp_r;
  logic [ROW_OUT_BITS-1:0] row_r;
  logic [COL_OUT_BITS-1:0] col_r;
  logic [SB-1:0]         rd_older_r, rd_prev_r;
  logic                  fwd_r;
  logic [SB-1:0]         fwd_older_r, fwd_prev_r;
  logic [SB-1:0]         win_r [3][3];
  logic [SB-1:0]         nw    [3][3];
  logic [SB-1:0]         dw_top_r [3];
  logic [SB-1:0]         dw_bot_r [3];

  logic [SB-1:0] older_e, prev_e;
  logic          we, drn;
  logic [WIN_N-1:0][SB-1:0] va, vb;
  logic [WIN_N-1:0]         ma, mb;
  logic [2:0]               colv;
  lane_meta_t               meta_a_nxt, meta_b_nxt;

  function automatic logic [SORT_N-1:0][SB:0] pad_lane(
    input logic [WIN_N-1:0][SB-1:0] v,
    input logic [WIN_N-1:0]         m
  );
    logic [SORT_N-1:0][SB:0] res;
    logic                    par;
    par = 1'b0;
    for (int i = 0; i < WIN_N; i++) begin
      if (m[i]) begin
        res[i] = {v[i][SB-1], v[i]};
      end else begin
        res[i] = par ? {1'b0, {SB{1'b1}}} : {1'b1, {SB{1'b0}}};
        par    = ~par;
      end
    end
    res[SORT_N-1] = {1'b0, {SB{1'b1}}};
    return res;
  endfunction

  assign older_e = fwd_r ? fwd_older_r : rd_older_r;
  assign prev_e  = fwd_r ? fwd_prev_r  : rd_prev_r;
  assign we      = adv && ctl_r.valid && !ctl_r.drain;
  assign drn     = adv && ctl_r.valid && ctl_r.drain;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_older_r <= older_mem[addr_in];
      rd_prev_r  <= prev_mem[addr_in];
    end
    if (we) begin
      older_mem[addr_r] <= prev_e;
      prev_mem[addr_r]  <= samp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
      fwd_r <= 1'b0;
    end else if (adv) begin
      ctl_r <= ctl_in;
      fwd_r <= we && (addr_r == addr_in);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      addr_r      <= addr_in;
      samp_r      <= samp_in;
      row_r       <= row_in;
      col_r       <= col_in;
      fwd_older_r <= prev_e;
      fwd_prev_r  <= samp_r;
    end
    if (we) begin
      win_r <= nw;
      if (ctl_r.cap0) begin
        dw_top_r[1] <= prev_e;
        dw_bot_r[1] <= samp_r;
      end
      if (ctl_r.cap1) begin
        dw_top_r[2] <= prev_e;
        dw_bot_r[2] <= samp_r;
      end
    end
    if (drn) begin
      dw_top_r[0] <= dw_top_r[1];
      dw_bot_r[0] <= dw_bot_r[1];
      dw_top_r[1] <= dw_top_r[2];
      dw_bot_r[1] <= dw_bot_r[2];
      dw_top_r[2] <= older_e;
      dw_bot_r[2] <= prev_e;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nw[r][0] = win_r[r][1];
      nw[r][1] = win_r[r][2];
    end
    nw[0][2] = older_e;
    nw[1][2] = prev_e;
    nw[2][2] = samp_r;
  end

  always_comb begin
    colv = {ctl_r.has_r, 1'b1, ctl_r.has_l};
    va   = '0;
    vb   = '0;
    ma   = '0;
    mb   = '0;
    if (ctl_r.drain) begin
      for (int c = 0; c < 3; c++) begin
        va[c*2]   = dw_top_r[c];
        va[c*2+1] = dw_bot_r[c];
        ma[c*2]   = colv[c] && ctl_r.use_older;
        ma[c*2+1] = colv[c];
      end
    end else begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          va[r*3+c] = nw[r][c];
          vb[r*3+c] = nw[r][c];
          ma[r*3+c] = (r != 0 || ctl_r.use_older) && (c != 0 || ctl_r.a_col0);
          mb[r*3+c] = (r != 0 || ctl_r.use_older) && (c != 0) && (c != 1 || ctl_r.b_col1);
        end
      end
    end
  end

  always_comb begin
    meta_a_nxt.vld  = ctl_r.valid && (ctl_r.drain || ctl_r.emit_a);
    meta_a_nxt.odd  = ^ma;
    meta_a_nxt.last = ctl_r.drain && ctl_r.last;
    meta_a_nxt.row  = row_r;
    meta_a_nxt.col  = ctl_r.drain ? col_r : col_r - COL_OUT_BITS'(1);
    meta_b_nxt.vld  = ctl_r.valid && !ctl_r.drain && ctl_r.emit_b;
    meta_b_nxt.odd  = ^mb;
    meta_b_nxt.last = 1'b0;
    meta_b_nxt.row  = row_r;
    meta_b_nxt.col  = col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_a_r <= '0;
      meta_b_r <= '0;
    end else if (adv) begin
      meta_a_r <= meta_a_nxt;
      meta_b_r <= meta_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_a_r <= pad_lane(va, ma);
      lane_b_r <= pad_lane(vb, mb);
    end
  end

endmodule

FILE: hw/rtl/cwmf_sort.sv
// Pipelined odd-even transposition sorter for one padded window lane.
// One compare-exchange round per stage; uses cwmf_pkg.
module cwmf_sort
  import cwmf_pkg::*;
#(
  parameter int W = DEF_SAMPLE_BITS + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic [SORT_N-1:0][W-1:0] din,
  input  lane_meta_t               meta_in,
  output logic [W-1:0]             mid_lo,
  output logic [W-1:0]             mid_hi,
  output lane_meta_t               meta_out
);

  logic [SORT_N-1:0][W-1:0] st [SORT_N+1];
  lane_meta_t               mt [SORT_N+1];

  assign st[0] = din;
  assign mt[0] = meta_in;

  for (genvar g = 0; g < SORT_N; g++) begin : g_round
    logic [SORT_N-1:0][W-1:0] cx;

    always_comb begin
      cx = st[g];
      for (int i = g % 2; i + 1 < SORT_N; i += 2) begin
        if ($signed(st[g][i]) > $signed(st[g][i+1])) begin
          cx[i]   = st[g][i+1];
          cx[i+1] = st[g][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[g+1] <= cx;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mt[g+1] <= '0;
      end else if (adv) begin
        mt[g+1] <= mt[g];
      end
    end
  end

  assign mid_lo   = st[SORT_N][SORT_N/2-1];
  assign mid_hi   = st[SORT_N][SORT_N/2];
  assign meta_out = mt[SORT_N];

endmodule

FILE: hw/rtl/cwmf_outq.sv
// Four-entry result queue that accepts up to two results per cycle.
// Feeds the output stream and gives the pipeline advance signal; uses cwmf_pkg.
module cwmf_outq
  import cwmf_pkg::*;
#(
  parameter int EW = DEF_SAMPLE_BITS + 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_a,
  input  logic [EW-1:0] data_a,
  input  logic          push_b,
  input  logic [EW-1:0] data_b,
  input  logic          pop,
  output logic          room,
  output logic          nempty,
  output logic [EW-1:0] head
);

  logic [EW-1:0] q_r [4];
  logic [1:0]    wr_r, rd_r;
  logic [2:0]    cnt_r;
  logic [1:0]    npush;
  logic          do_pop;

  assign nempty = (cnt_r != 3'd0);
  assign room   = (cnt_r <= 3'd2);
  assign head   = q_r[rd_r];
  assign do_pop = pop && nempty;
  assign npush  = {1'b0, push_a} + {1'b0, push_b};

  always_ff @(posedge clk) begin
    if (push_a) begin
      q_r[wr_r] <= data_a;
    end
    if (push_b) begin
      q_r[push_a ? wr_r + 2'd1 : wr_r] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + npush;
      rd_r  <= rd_r + {1'b0, do_pop};
      cnt_r <= cnt_r + {1'b0, npush} - {2'b0, do_pop};
    end
  end

endmodule

FILE: hw/rtl/clipped_window_median_filter_unit.sv
// Top level of the clipped window median filter: counters, registers and pipeline glue.
// Instantiates cwmf_lines, cwmf_sort and cwmf_outq; uses cwmf_pkg.
//
//   Port group | Direction | Carries
//   in_*       | slave     | tdata: sample_value; tuser: func
//   out_*      | master    | tdata: median_x2, out_row, out_col; tlast: frame_last
//   cfg_*      | write     | grid_cols (index 0), grid_rows (index 1)
//
// One item per cycle is accepted while the result queue has room.
// Last-column samples past row 0 give two results if cols > 1; the queue sends both.
// The line stores are read at acceptance and written back as the registered item advances.
// Reset is synchronous and needs no clearing pass. A stalled output halts the whole
// pipeline once the four-entry result queue holds three results.
module clipped_window_median_filter_unit
  import cwmf_pkg::*;
#(
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((SAMPLE_BITS + 1 + ROW_OUT_BITS + COL_OUT_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TDATA_W-1:0]    in_tdata,   // sample_value
  input  logic [0:0]               in_tuser,   // func
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_TDATA_W-1:0]   out_tdata,  // median_x2, out_row, out_col
  output logic                     out_tlast,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int MW  = SB + 1;
  localparam int EW  = MW + ROW_OUT_BITS + COL_OUT_BITS + 1;
  localparam int RST_COLS = (RST_GRID_COLS > MAX_COLS) ? MAX_COLS : RST_GRID_COLS;
  localparam int RST_ROWS = (RST_GRID_ROWS > MAX_ROWS) ? MAX_ROWS : RST_GRID_ROWS;

  logic [CCW-1:0] cols_r, col_cnt_r;
  logic [RCW-1:0] rows_r, row_cnt_r;
  logic [CCW-1:0] cols_clamp;
  logic [RCW-1:0] rows_clamp;
  logic [COLS_REG_BITS-1:0] wv_cols;
  logic [ROWS_REG_BITS-1:0] wv_rows;

  logic adv, acc, is_drain, samp_ok, drn_ok, col_last;
  item_ctl_t ctl;
  logic [AW-1:0] addr;
  logic [ROW_OUT_BITS-1:0] pt_row;
  logic [COL_OUT_BITS-1:0] pt_col;

  logic [SORT_N-1:0][MW-1:0] lane_a, lane_b;
  lane_meta_t meta_a, meta_b, meta_a_o, meta_b_o;
  logic [MW-1:0] a_lo, a_hi, b_lo, b_hi;
  logic [MW-1:0] med_a, med_b;
  logic [MW:0]   sum_a, sum_b;
  logic [EW-1:0] ent_a, ent_b, head;
  logic          room, nempty;

  assign wv_cols = cfg_wdata[COLS_REG_BITS-1:0];
  assign wv_rows = cfg_wdata[ROWS_REG_BITS-1:0];

  always_comb begin
    if (wv_cols == '0) begin
      cols_clamp = CCW'(1);
    end else if (32'(wv_cols) > 32'(MAX_COLS)) begin
      cols_clamp = CCW'(MAX_COLS);
    end else begin
      cols_clamp = CCW'(wv_cols);
    end
    if (wv_rows == '0) begin
      rows_clamp = RCW'(1);
    end else if (32'(wv_rows) > 32'(MAX_ROWS)) begin
      rows_clamp = RCW'(MAX_ROWS);
    end else begin
      rows_clamp = RCW'(wv_rows);
    end
  end

  assign adv       = room;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;
  assign is_drain  = (in_tuser[0] == FUNC_DRAIN);
  assign col_last  = (col_cnt_r == cols_r - CCW'(1));
  assign samp_ok   = !is_drain && (row_cnt_r < rows_r) && (col_cnt_r < cols_r);
  assign drn_ok    = is_drain && (row_cnt_r >= rows_r) && (col_cnt_r < cols_r);

  always_comb begin
    ctl.valid     = acc && (samp_ok || drn_ok);
    ctl.drain     = is_drain;
    ctl.emit_a    = (row_cnt_r >= RCW'(1)) && (col_cnt_r >= CCW'(1));
    ctl.emit_b    = (row_cnt_r >= RCW'(1)) && col_last;
    ctl.use_older = is_drain ? (rows_r >= RCW'(2)) : (row_cnt_r >= RCW'(2));
    ctl.a_col0    = (col_cnt_r >= CCW'(2));
    ctl.b_col1    = (col_cnt_r >= CCW'(1));
    ctl.cap0      = (row_cnt_r == rows_r - RCW'(1)) && (col_cnt_r == CCW'(0));
    ctl.cap1      = (row_cnt_r == rows_r - RCW'(1)) && (col_cnt_r == CCW'(1));
    ctl.has_l     = (col_cnt_r >= CCW'(1));
    ctl.has_r     = !col_last;
    ctl.last      = col_last;
    addr   = is_drain ? AW'(col_cnt_r + CCW'(2)) : AW'(col_cnt_r);
    pt_row = is_drain ? ROW_OUT_BITS'(rows_r - RCW'(1)) : ROW_OUT_BITS'(row_cnt_r - RCW'(1));
    pt_col = COL_OUT_BITS'(col_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r    <= CCW'(RST_COLS);
      rows_r    <= RCW'(RST_ROWS);
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_GRID_COLS) begin
        cols_r    <= cols_clamp;
        col_cnt_r <= '0;
        row_cnt_r <= '0;
      end else if (cfg_addr == REG_GRID_ROWS) begin
        rows_r    <= rows_clamp;
        col_cnt_r <= '0;
        row_cnt_r <= '0;
      end
    end else if (acc && samp_ok) begin
      if (col_last) begin
        col_cnt_r <= '0;
        row_cnt_r <= row_cnt_r + RCW'(1);
      end else begin
        col_cnt_r <= col_cnt_r + CCW'(1);
      end
    end else if (acc && drn_ok) begin
      if (col_last) begin
        col_cnt_r <= '0;
        row_cnt_r <= '0;
      end else begin
        col_cnt_r <= col_cnt_r + CCW'(1);
      end
    end
  end

  cwmf_lines #(
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lines (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .ctl_in   (ctl),
    .addr_in  (addr),
    .samp_in  (in_tdata[SB-1:0]),
    .row_in   (pt_row),
    .col_in   (pt_col),
    .lane_a_r (lane_a),
    .lane_b_r (lane_b),
    .meta_a_r (meta_a),
    .meta_b_r (meta_b)
  );

  cwmf_sort #(.W(MW)) u_sort_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .din      (lane_a),
    .meta_in  (meta_a),
    .mid_lo   (a_lo),
    .mid_hi   (a_hi),
    .meta_out (meta_a_o)
  );

  cwmf_sort #(.W(MW)) u_sort_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .din      (lane_b),
    .meta_in  (meta_b),
    .mid_lo   (b_lo),
    .mid_hi   (b_hi),
    .meta_out (meta_b_o)
  );

  assign sum_a = {a_lo[MW-1], a_lo} + {a_hi[MW-1], a_hi};
  assign sum_b = {b_lo[MW-1], b_lo} + {b_hi[MW-1], b_hi};
  assign med_a = meta_a_o.odd ? {a_lo[MW-2:0], 1'b0} : sum_a[MW-1:0];
  assign med_b = meta_b_o.odd ? {b_lo[MW-2:0], 1'b0} : sum_b[MW-1:0];
  assign ent_a = {meta_a_o.last, meta_a_o.col, meta_a_o.row, med_a};
  assign ent_b = {meta_b_o.last, meta_b_o.col, meta_b_o.row, med_b};

  cwmf_outq #(.EW(EW)) u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_a (adv && meta_a_o.vld),
    .data_a (ent_a),
    .push_b (adv && meta_b_o.vld),
    .data_b (ent_b),
    .pop    (out_tready),
    .room   (room),
    .nempty (nempty),
    .head   (head)
  );

  assign out_tvalid = nempty;
  assign out_tdata  = OUT_TDATA_W'(head[EW-2:0]);
  assign out_tlast  = head[EW-1];

endmodule

FILE: hw/rtl/cwmf_checker.sv
// Port-level checker for the clipped window median filter unit, bound to the top level.
// Uses the assertion macros of clipped_window_median_filter_unit_defines.svh.
`include "clipped_window_median_filter_unit_defines.svh"

module cwmf_checker
  import cwmf_pkg::*;
#(
  parameter int OUT_TDATA_W = 56
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  `CWMF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `CWMF_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")
  `CWMF_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid, "result pending after reset")
  `CWMF_ASSERT_SAME(a_full_has_data, !in_tready, out_tvalid, "input stalled with no result to send")

endmodule

bind clipped_window_median_filter_unit cwmf_checker #(
  .OUT_TDATA_W (OUT_TDATA_W)
) u_cwmf_checker (.*);

FILE: tb/clipped_window_median_filter_unit_tb.sv
// Testbench of clipped_window_median_filter_unit: frames of samples stream in, medians stream out.
// A built-in predictor of the clipped 3x3 window checks every result; uses cwmf_pkg and the unit.
`timescale 1ns / 1ps

module clipped_window_median_filter_unit_tb
  import cwmf_pkg::*;
();

  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic        func;
    logic [31:0] value;
  } grid_item_t;

  typedef struct {
    logic signed [32:0] med_x2;
    logic [11:0]        row;
    logic [9:0]         col;
    logic               last;
  } median_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  clipped_window_median_filter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  grid_item_t  pending_items[$];
  median_res_t expected_medians[$];

  logic signed [31:0] older_row[DEF_MAX_COLS];
  logic signed [31:0] prev_row[DEF_MAX_COLS];
  logic signed [31:0] win[3][3];
  int row_cnt, col_cnt, cols_used, rows_used;
  int errors = 0;
  int accepted = 0;
  logic in_taken = 1'b0;
  logic out_hold = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic int pick_gap();
    int r;
    if ((accepted / 128) % 3 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [32:0] mid_x2(input longint v[9], input int n);
    longint t;
    int j;
    for (int i = 1; i < n; i++) begin
      t = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > t) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = t;
    end
    if (n % 2 == 1) return 2 * v[n / 2];
    return v[n / 2 - 1] + v[n / 2];
  endfunction

  function automatic logic signed [32:0] window_mid_x2(input int rlo, input int clo);
    longint v[9];
    int n;
    n = 0;
    for (int r = rlo; r < 3; r++)
      for (int c = clo; c < 3; c++) begin
        v[n] = win[r][c];
        n++;
      end
    return mid_x2(v, n);
  endfunction

  function automatic void push_median(logic signed [32:0] m, int row, int col, logic last);
    median_res_t e;
    e.med_x2 = m;
    e.row = row[11:0];
    e.col = col[9:0];
    e.last = last;
    expected_medians = {expected_medians, e};
  endfunction

  function automatic void predict_medians(logic func, logic signed [31:0] s);
    longint v[9];
    int n, c;
    if (func == FUNC_DRAIN) begin
      if (row_cnt < rows_used || col_cnt >= cols_used) return;
      n = 0;
      for (int dc = -1; dc <= 1; dc++) begin
        c = col_cnt + dc;
        if (c < 0 || c >= cols_used) continue;
        if (rows_used >= 2) begin
          v[n] = older_row[c];
          n++;
        end
        v[n] = prev_row[c];
        n++;
      end
      push_median(mid_x2(v, n), rows_used - 1, col_cnt, col_cnt == cols_used - 1);
      col_cnt++;
      if (col_cnt >= cols_used) begin
        col_cnt = 0;
        row_cnt = 0;
      end
    end else begin
      if (row_cnt >= rows_used || col_cnt >= cols_used) return;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = older_row[col_cnt];
      win[1][2] = prev_row[col_cnt];
      win[2][2] = s;
      older_row[col_cnt] = prev_row[col_cnt];
      prev_row[col_cnt] = s;
      if (row_cnt >= 1) begin
        if (col_cnt >= 1)
          push_median(window_mid_x2(row_cnt >= 2 ? 0 : 1, col_cnt >= 2 ? 0 : 1),
                      row_cnt - 1, col_cnt - 1, 1'b0);
        if (col_cnt == cols_used - 1)
          push_median(window_mid_x2(row_cnt >= 2 ? 0 : 1, col_cnt >= 1 ? 1 : 2),
                      row_cnt - 1, col_cnt, 1'b0);
      end
      col_cnt++;
      if (col_cnt >= cols_used) begin
        col_cnt = 0;
        row_cnt++;
      end
    end
  endfunction

  // Input side: accept on the rising edge, present the next item on the falling edge.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      predict_medians(in_tuser[0], in_tdata);
      accepted++;
    end
  end

  always @(negedge clk) begin
    grid_item_t it;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_tdata <= it.value;
        in_tuser <= it.func;
        in_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || out_hold) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    median_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_medians.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result transfer: tdata=%h tlast=%b", out_tdata, out_tlast);
      end else begin
        e = expected_medians.pop_front();
        if (out_tdata[32:0] !== e.med_x2 || out_tdata[44:33] !== e.row ||
            out_tdata[54:45] !== e.col || out_tlast !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected med_x2=%0d row=%0d col=%0d last=%b, got %0d %0d %0d %b",
                     e.med_x2, e.row, e.col, e.last, $signed(out_tdata[32:0]),
                     out_tdata[44:33], out_tdata[54:45], out_tlast);
        end
      end
    end
  end

  // The receiver holds off for a long stretch while the sender keeps offering items.
  initial begin
    while (accepted < 60) @(posedge clk);
    out_hold = 1'b1;
    repeat (300) @(posedge clk);
    out_hold = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("clipped_window_median_filter_unit test failed");
    $finish;
  end

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_tvalid || expected_medians.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v[CFG_DATA_BITS-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GRID_COLS) begin
      cols_used = v[10:0];
      if (cols_used < 1) cols_used = 1;
      if (cols_used > DEF_MAX_COLS) cols_used = DEF_MAX_COLS;
    end else if (idx == REG_GRID_ROWS) begin
      rows_used = v[12:0];
      if (rows_used < 1) rows_used = 1;
      if (rows_used > DEF_MAX_ROWS) rows_used = DEF_MAX_ROWS;
    end else begin
      return;
    end
    row_cnt = 0;
    col_cnt = 0;
  endtask

  task automatic queue_item(logic func, logic [31:0] value);
    grid_item_t it;
    it.func = func;
    it.value = value;
    pending_items = {pending_items, it};
  endtask

  // One frame: wait for idle, noise if asked, all samples, then drains; incomplete: half the samples.
  task automatic run_frame(input int cols_w, input int rows_w, input bit noise,
                           input bit complete);
    int n;
    wait_idle();
    write_reg(REG_GRID_COLS, cols_w);
    write_reg(REG_GRID_ROWS, rows_w);
    if (noise) queue_item(FUNC_DRAIN, $urandom);
    n = rows_used * cols_used;
    if (!complete) n = n / 2;
    for (int i = 0; i < n; i++) queue_item(FUNC_SAMPLE, rand_sample());
    if (!complete) return;
    if (noise) queue_item(FUNC_SAMPLE, $urandom);
    for (int i = 0; i < cols_used; i++) queue_item(FUNC_DRAIN, $urandom);
    if (noise) queue_item(FUNC_DRAIN, $urandom);
  endtask

  initial begin
    cols_used = RST_GRID_COLS;
    rows_used = RST_GRID_ROWS;
    row_cnt = 0;
    col_cnt = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_SPARE_A, 13'h1fff);
    write_reg(REG_SPARE_B, 0);
    run_frame(3, 3, 1'b1, 1'b1);
    run_frame(1, 1, 1'b1, 1'b1);
    run_frame(1, 2, 1'b0, 1'b1);
    run_frame(2, 1, 1'b1, 1'b1);
    run_frame(0, 0, 1'b0, 1'b1);
    run_frame(5, 4, 1'b0, 1'b0);
    run_frame(4, 5, 1'b1, 1'b1);
    run_frame(16, 3, 1'b1, 1'b1);
    run_frame(1, 8, 1'b0, 1'b1);
    for (int k = 0; k < 13; k++)
      run_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 1),
                $urandom_range(0, 7) != 0);
    wait_idle();
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("clipped_window_median_filter_unit test passed");
    else
      $display("clipped_window_median_filter_unit test failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/cwmf_pkg.sv
hw/rtl/cwmf_lines.sv
hw/rtl/cwmf_sort.sv
hw/rtl/cwmf_outq.sv
hw/rtl/clipped_window_median_filter_unit.sv
hw/rtl/cwmf_checker.sv
tb/clipped_window_median_filter_unit_tb.sv
